@@ sv/spma_pkg.sv @@
package spma_pkg;

  // default sizing
  localparam int unsigned MAX_TERMS_DEF = 1024;
  localparam int unsigned MAX_EXPO_DEF  = 1023;
  localparam int unsigned COEF_BITS_DEF = 16;

  // result coefficient width, fixed by the interface
  localparam int unsigned OUT_COEF_W = 48;

  // request codes
  localparam logic [1:0] FUNC_LOAD_A = 2'd0;
  localparam logic [1:0] FUNC_LOAD_B = 2'd1;
  localparam logic [1:0] FUNC_FETCH  = 2'd2;

  // result run codes
  localparam logic PHASE_PROD = 1'b0;
  localparam logic PHASE_SUM  = 1'b1;

endpackage

@@ sv/sparse_polynomial_multiply_add.sv @@
// channel  | direction | handshake              | payload
// ---------+-----------+------------------------+-------------------------------------------
// request  | in        | start high, busy low   | func_i, term_coef_i, term_expo_i
// result   | out       | strobe_o, one cycle    | which_result_o, out_coef_o, out_expo_o,
//          |           |                        | last_of_run_o
//
// first-polynomial load: term store write, then sum store read-modify-write
// second-polynomial load: one stored first term per cycle through the product store
//   read-modify-write pipeline
// fetch: walks down the coefficient store being read one exponent at a time, through
//   its single read port
// after reset and after the final sum term a clearing pass zeroes the coefficient
//   stores; busy stays high throughout
// the receiver cannot stall: each result is shown for one cycle only
module sparse_polynomial_multiply_add #(
  parameter int unsigned MAX_TERMS = spma_pkg::MAX_TERMS_DEF,
  parameter int unsigned MAX_EXPO  = spma_pkg::MAX_EXPO_DEF,
  parameter int unsigned COEF_BITS = spma_pkg::COEF_BITS_DEF,
  localparam int unsigned EXP_W    = $clog2(MAX_EXPO + 1),
  localparam int unsigned OEXP_W   = $clog2(2 * MAX_EXPO + 1)
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     start,
  output logic                                     busy,
  input  logic [1:0]                               func_i,
  input  logic signed [COEF_BITS-1:0]              term_coef_i,
  input  logic [EXP_W-1:0]                         term_expo_i,
  output logic                                     strobe_o,
  output logic                                     which_result_o,
  output logic signed [spma_pkg::OUT_COEF_W-1:0]   out_coef_o,
  output logic [OEXP_W-1:0]                        out_expo_o,
  output logic                                     last_of_run_o
);

  localparam int unsigned CW         = spma_pkg::OUT_COEF_W;
  localparam int unsigned PROD_TOP   = 2 * MAX_EXPO;
  localparam int unsigned PROD_DEPTH = PROD_TOP + 1;
  localparam int unsigned SUM_DEPTH  = MAX_EXPO + 1;
  localparam int unsigned SUM_W      = COEF_BITS + 1;
  localparam int unsigned FA_W       = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int unsigned CNT_W      = $clog2(MAX_TERMS + 1);
  localparam int unsigned FT_W       = COEF_BITS + EXP_W;
  localparam int unsigned PW         = 2 * COEF_BITS;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SUMW  = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_CLEAR = 3'd5;

  // memories: first-polynomial terms, product and sum coefficients
  logic [FT_W-1:0]         first_mem [MAX_TERMS];
  logic [CW-1:0]           prod_mem  [PROD_DEPTH];
  logic signed [SUM_W-1:0] sum_mem   [SUM_DEPTH];

  logic [FT_W-1:0]         first_rd_q;
  logic [CW-1:0]           prod_rd_q;
  logic signed [SUM_W-1:0] sum_rd_q;

  // control state
  logic [2:0]        state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  k_q, k_d;
  logic              sum_pend_q, sum_pend_d;
  logic              f_valid_q, f_valid_d;
  logic              m_valid_q, m_valid_d;
  logic              w_valid_q, w_valid_d;
  logic              l_valid_q, l_valid_d;
  logic              phase_q, phase_d;
  logic [OEXP_W-1:0] ptr_q, ptr_d;
  logic [OEXP_W-1:0] iss_addr_q, iss_addr_d;
  logic              iss_live_q, iss_live_d;
  logic              ret_valid_q, ret_valid_d;
  logic [OEXP_W-1:0] ret_addr_q, ret_addr_d;
  logic              found_q, found_d;
  logic [OEXP_W-1:0] clr_q, clr_d;
  logic              strobe_q, strobe_d;

  // payload registers
  logic signed [COEF_BITS-1:0] c_q;
  logic [EXP_W-1:0]            e_q;
  logic [OEXP_W-1:0]           m_pe_q, m_pe_d;
  logic [CW-1:0]               m_prod_q, m_prod_d;
  logic [OEXP_W-1:0]           w_pe_q;
  logic [CW-1:0]               w_prod_q;
  logic [OEXP_W-1:0]           l_pe_q;
  logic [CW-1:0]               l_data_q;
  logic [CW-1:0]               hit_coef_q, hit_coef_d;
  logic [OEXP_W-1:0]           hit_addr_q, hit_addr_d;
  logic                        which_q, which_d;
  logic [CW-1:0]               coef_q, coef_d;
  logic [OEXP_W-1:0]           expo_q, expo_d;
  logic                        last_q, last_d;

  // datapath signals
  logic                    accept;
  logic                    ld_ok;
  logic                    first_we;
  logic signed [PW-1:0]    mul;
  logic [CW-1:0]           prod_old;
  logic [CW-1:0]           prod_new;
  logic                    prod_we;
  logic [OEXP_W-1:0]       prod_waddr;
  logic [CW-1:0]           prod_wdata;
  logic [OEXP_W-1:0]       prod_raddr;
  logic                    sum_we;
  logic [EXP_W-1:0]        sum_waddr;
  logic signed [SUM_W-1:0] sum_wdata;
  logic [EXP_W-1:0]        sum_raddr;
  logic [CW-1:0]           scan_data;
  logic                    scan_nz;

  assign busy   = (state_q != S_IDLE);
  assign accept = start & ~busy;
  // loads beyond the top exponent are dropped
  assign ld_ok  = (term_expo_i <= EXP_W'(MAX_EXPO));

  // memory port selection
  assign first_we   = accept && (func_i == spma_pkg::FUNC_LOAD_A) && ld_ok
                      && (count_q < CNT_W'(MAX_TERMS));
  assign prod_raddr = (state_q == S_SCAN) ? iss_addr_q : m_pe_q;
  assign sum_raddr  = (state_q == S_SCAN) ? iss_addr_q[EXP_W-1:0] : term_expo_i;

  always_comb begin
    // the last write, made at the same edge as the read and so missed by it, is forwarded
    prod_old = (l_valid_q && (l_pe_q == w_pe_q)) ? l_data_q : prod_rd_q;
    prod_new = prod_old + w_prod_q;
    if (state_q == S_CLEAR) begin
      prod_we    = 1'b1;
      prod_waddr = clr_q;
      prod_wdata = '0;
      sum_we     = (clr_q <= OEXP_W'(MAX_EXPO));
      sum_waddr  = clr_q[EXP_W-1:0];
      sum_wdata  = '0;
    end else begin
      prod_we    = w_valid_q;
      prod_waddr = w_pe_q;
      prod_wdata = prod_new;
      sum_we     = sum_pend_q;
      sum_waddr  = e_q;
      sum_wdata  = sum_rd_q + SUM_W'(c_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (first_we) begin
      first_mem[count_q[FA_W-1:0]] <= {term_coef_i, term_expo_i};
    end
    first_rd_q <= first_mem[k_q[FA_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (prod_we) begin
      prod_mem[prod_waddr] <= prod_wdata;
    end
    prod_rd_q <= prod_mem[prod_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (sum_we) begin
      sum_mem[sum_waddr] <= sum_wdata;
    end
    sum_rd_q <= sum_mem[sum_raddr];
  end

  // product pipeline: term read, multiply, product store read, accumulate
  always_comb begin
    mul      = $signed(first_rd_q[FT_W-1:EXP_W]) * c_q;
    m_prod_d = CW'(mul);
    m_pe_d   = OEXP_W'(first_rd_q[EXP_W-1:0]) + OEXP_W'(e_q);
  end

  // coefficient coming back from the scanned store, sum widened with its sign
  assign scan_data = (phase_q == spma_pkg::PHASE_SUM) ? CW'(sum_rd_q) : prod_rd_q;
  assign scan_nz   = (scan_data != '0);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    k_d         = k_q;
    sum_pend_d  = 1'b0;
    f_valid_d   = 1'b0;
    m_valid_d   = f_valid_q;
    w_valid_d   = m_valid_q;
    l_valid_d   = w_valid_q;
    phase_d     = phase_q;
    ptr_d       = ptr_q;
    iss_addr_d  = iss_addr_q;
    iss_live_d  = iss_live_q;
    ret_valid_d = 1'b0;
    ret_addr_d  = iss_addr_q;
    found_d     = found_q;
    hit_coef_d  = hit_coef_q;
    hit_addr_d  = hit_addr_q;
    clr_d       = clr_q;
    strobe_d    = 1'b0;
    which_d     = phase_q;
    coef_d      = coef_q;
    expo_d      = expo_q;
    last_d      = last_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (func_i)
            spma_pkg::FUNC_LOAD_A: begin
              if (first_we) begin
                count_d    = count_q + CNT_W'(1);
                sum_pend_d = 1'b1;
                state_d    = S_SUMW;
              end
            end
            spma_pkg::FUNC_LOAD_B: begin
              if (ld_ok) begin
                sum_pend_d = 1'b1;
                k_d        = '0;
                state_d    = S_MUL;
              end
            end
            spma_pkg::FUNC_FETCH: begin
              iss_addr_d = ptr_q;
              iss_live_d = 1'b1;
              found_d    = 1'b0;
              state_d    = S_SCAN;
            end
            default: begin
              // unknown request, nothing to do
            end
          endcase
        end
      end

      S_SUMW: begin
        state_d = S_IDLE;
      end

      S_MUL: begin
        if (k_q < count_q) begin
          f_valid_d = 1'b1;
          k_d       = k_q + CNT_W'(1);
        end else begin
          state_d = S_DRAIN;
        end
      end

      S_DRAIN: begin
        if (!f_valid_q && !m_valid_q && !w_valid_q) begin
          state_d = S_IDLE;
        end
      end

      S_SCAN: begin
        // issue side walks down one exponent a cycle
        ret_valid_d = iss_live_q;
        if (iss_live_q) begin
          if (iss_addr_q == '0) begin
            iss_live_d = 1'b0;
          end else begin
            iss_addr_d = iss_addr_q - OEXP_W'(1);
          end
        end
        // return side, handling each read in the cycle after its issue
        if (ret_valid_q) begin
          if (scan_nz && found_q) begin
            // a further term exists below the hit
            strobe_d = 1'b1;
            coef_d   = hit_coef_q;
            expo_d   = hit_addr_q;
            last_d   = 1'b0;
            ptr_d    = hit_addr_q - OEXP_W'(1);
            state_d  = S_IDLE;
          end else if (ret_addr_q == '0) begin
            strobe_d = 1'b1;
            last_d   = 1'b1;
            if (scan_nz) begin
              coef_d = scan_data;
              expo_d = '0;
            end else if (found_q) begin
              coef_d = hit_coef_q;
              expo_d = hit_addr_q;
            end else begin
              // empty run
              coef_d = '0;
              expo_d = '0;
            end
            if (phase_q == spma_pkg::PHASE_PROD) begin
              phase_d = spma_pkg::PHASE_SUM;
              ptr_d   = OEXP_W'(MAX_EXPO);
              state_d = S_IDLE;
            end else begin
              // both runs delivered, start over from empty stores
              phase_d = spma_pkg::PHASE_PROD;
              ptr_d   = OEXP_W'(PROD_TOP);
              count_d = '0;
              clr_d   = '0;
              state_d = S_CLEAR;
            end
          end else if (scan_nz) begin
            found_d    = 1'b1;
            hit_coef_d = scan_data;
            hit_addr_d = ret_addr_q;
          end
        end
      end

      S_CLEAR: begin
        if (clr_q == OEXP_W'(PROD_TOP)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + OEXP_W'(1);
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      count_q     <= '0;
      k_q         <= '0;
      sum_pend_q  <= 1'b0;
      f_valid_q   <= 1'b0;
      m_valid_q   <= 1'b0;
      w_valid_q   <= 1'b0;
      l_valid_q   <= 1'b0;
      phase_q     <= spma_pkg::PHASE_PROD;
      ptr_q       <= OEXP_W'(PROD_TOP);
      iss_addr_q  <= '0;
      iss_live_q  <= 1'b0;
      ret_valid_q <= 1'b0;
      ret_addr_q  <= '0;
      found_q     <= 1'b0;
      clr_q       <= '0;
      strobe_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      k_q         <= k_d;
      sum_pend_q  <= sum_pend_d;
      f_valid_q   <= f_valid_d;
      m_valid_q   <= m_valid_d;
      w_valid_q   <= w_valid_d;
      l_valid_q   <= l_valid_d;
      phase_q     <= phase_d;
      ptr_q       <= ptr_d;
      iss_addr_q  <= iss_addr_d;
      iss_live_q  <= iss_live_d;
      ret_valid_q <= ret_valid_d;
      ret_addr_q  <= ret_addr_d;
      found_q     <= found_d;
      clr_q       <= clr_d;
      strobe_q    <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      c_q <= term_coef_i;
      e_q <= term_expo_i;
    end
    m_pe_q     <= m_pe_d;
    m_prod_q   <= m_prod_d;
    w_pe_q     <= m_pe_q;
    w_prod_q   <= m_prod_q;
    l_pe_q     <= w_pe_q;
    l_data_q   <= prod_new;
    hit_coef_q <= hit_coef_d;
    hit_addr_q <= hit_addr_d;
    which_q    <= which_d;
    coef_q     <= coef_d;
    expo_q     <= expo_d;
    last_q     <= last_d;
  end

  assign strobe_o       = strobe_q;
  assign which_result_o = which_q;
  assign out_coef_o     = coef_q;
  assign out_expo_o     = expo_q;
  assign last_of_run_o  = last_q;

  // results only ever leave the scan
  a_strobe_from_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q |-> $past(state_q == S_SCAN))
    else $error("result strobe without a scan");

  // accumulate writes only while a second-polynomial term is in flight
  a_acc_in_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    w_valid_q |-> (state_q == S_MUL || state_q == S_DRAIN))
    else $error("product write outside multiply");

  // term index never runs past the stored first terms
  a_k_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL) |-> (k_q <= count_q))
    else $error("term index beyond first count");

  // a fetch request goes straight into the scan
  a_fetch_scans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && func_i == spma_pkg::FUNC_FETCH) |=> (state_q == S_SCAN))
    else $error("fetch did not start a scan");

  // clearing pass never overlaps an update
  a_clear_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> (!sum_pend_q && !w_valid_q))
    else $error("store update during clearing pass");

endmodule
